FILE: rtl/bdpt_pkg.sv
// Package for the button debouncer with press timer.
// Holds the widths, configuration indexes and result type shared by the RTL files.
// No dependencies.
package bdpt_pkg;

    localparam int DELAY_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_DELAY = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE_LEVEL   = 1'd1;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(50);

    typedef struct packed {
        logic                 pressed_event;
        logic                 released_event;
        logic [TIME_BITS-1:0] press_duration;
        logic                 debounced_on;
    } result_t;

endpackage

FILE: rtl/bdpt_fsm.sv
// Debounce state machine, delay counter and press-time counter.
// Advances once per item and returns that item's result combinationally.
// Depends on bdpt_pkg.
module bdpt_fsm (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             pin_level,
    input  logic [bdpt_pkg::DELAY_BITS-1:0]  debounce_delay,
    input  logic                             active_level,
    output bdpt_pkg::result_t                res
);
    import bdpt_pkg::*;

    localparam logic [1:0] ST_OFF  = 2'd0;
    localparam logic [1:0] ST_RISE = 2'd1;
    localparam logic [1:0] ST_ON   = 2'd2;
    localparam logic [1:0] ST_FALL = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [DELAY_BITS-1:0] delay_left_reg, delay_left_next;
    logic [TIME_BITS-1:0]  press_ticks_reg, press_ticks_next;

    logic                  level;
    logic [DELAY_BITS-1:0] load_value;
    logic [DELAY_BITS-1:0] delay_dec;
    logic                  expired;

    assign level      = (pin_level == active_level);
    // a zero delay behaves as one tick
    assign load_value = (debounce_delay == '0) ? DELAY_BITS'(1) : debounce_delay;
    assign delay_dec  = (delay_left_reg != '0) ? delay_left_reg - DELAY_BITS'(1)
                                               : '0;
    assign expired    = (delay_dec == '0);

    always_comb
    begin
        state_next         = state_reg;
        delay_left_next    = delay_left_reg;
        press_ticks_next   = press_ticks_reg + TIME_BITS'(1);
        res.pressed_event  = 1'b0;
        res.released_event = 1'b0;
        res.press_duration = '0;
        unique case (state_reg)
            ST_OFF:
            begin
                if (level)
                begin
                    state_next       = ST_RISE;
                    delay_left_next  = load_value;
                    press_ticks_next = '0;
                end
            end
            ST_ON:
            begin
                if (!level)
                begin
                    state_next      = ST_FALL;
                    delay_left_next = load_value;
                end
            end
            ST_RISE:
            begin
                delay_left_next = delay_dec;
                if (expired)
                begin
                    state_next        = level ? ST_ON : ST_OFF;
                    res.pressed_event = level;
                end
            end
            default:
            begin
                delay_left_next = delay_dec;
                if (expired)
                begin
                    state_next = level ? ST_ON : ST_OFF;
                    if (!level)
                    begin
                        res.released_event = 1'b1;
                        res.press_duration = press_ticks_next;
                    end
                end
            end
        endcase
        res.debounced_on = (state_next == ST_ON) || (state_next == ST_FALL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_OFF;
            delay_left_reg  <= '0;
            press_ticks_reg <= '0;
        end
        else if (step)
        begin
            state_reg       <= state_next;
            delay_left_reg  <= delay_left_next;
            press_ticks_reg <= press_ticks_next;
        end
    end

endmodule

FILE: rtl/button_debouncer_with_press_timer.sv
// Top level of the button debouncer with press timer.
// Input register, configuration registers and result register around bdpt_fsm.
// Depends on bdpt_pkg and bdpt_fsm.
module button_debouncer_with_press_timer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [bdpt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bdpt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 pin_level,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 pressed_event,
    output logic                                 released_event,
    output logic [bdpt_pkg::TIME_BITS-1:0]       press_duration,
    output logic                                 debounced_on
);
    // One item is one tick carrying the raw pin level; each item gives exactly
    // one result. The block takes one item per cycle while results are taken:
    // an item is captured in the input register, runs through the state update
    // and lands in the result register, which shows its result. Both registers
    // stall together when the result is not taken. Configuration takes effect
    // for the next item; a bounce in progress keeps its loaded delay.
    import bdpt_pkg::*;

    logic                  in_valid_reg;
    logic                  pin_reg;
    logic                  out_valid_reg;
    result_t               res_reg;
    result_t               res_next;
    logic [DELAY_BITS-1:0] delay_cfg_reg;
    logic                  active_cfg_reg;
    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cfg_reg  <= DELAY_RESET;
            active_cfg_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_DELAY: delay_cfg_reg  <= cfg_data[DELAY_BITS-1:0];
                CFG_ACTIVE_LEVEL:   active_cfg_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pin_reg <= pin_level;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    bdpt_fsm u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .pin_level      (pin_reg),
        .debounce_delay (delay_cfg_reg),
        .active_level   (active_cfg_reg),
        .res            (res_next)
    );

    assign out_valid      = out_valid_reg;
    assign pressed_event  = res_reg.pressed_event;
    assign released_event = res_reg.released_event;
    assign press_duration = res_reg.press_duration;
    assign debounced_on   = res_reg.debounced_on;

endmodule

FILE: rtl/bdpt_checker.sv
// Port-level checker for the button debouncer with press timer.
// Bound to button_debouncer_with_press_timer; depends on bdpt_pkg.
module bdpt_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [bdpt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bdpt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 pin_level,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 pressed_event,
    input  logic                                 released_event,
    input  logic [bdpt_pkg::TIME_BITS-1:0]       press_duration,
    input  logic                                 debounced_on
);
    import bdpt_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pressed_event)
            && $stable(released_event) && $stable(press_duration)
            && $stable(debounced_on))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pressed_event && released_event))
        else $error("press and release in one item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_duration != '0 |-> released_event)
        else $error("press duration without release");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pressed_event || released_event) |-> debounced_on == pressed_event)
        else $error("debounced level disagrees with event");

endmodule

bind button_debouncer_with_press_timer bdpt_checker u_bdpt_checker (.*);
